[rtl/core/hmcs_pkg.sv]
// hmcs_pkg: shared types and constants of the h-bridge motor command sequencer
// used by every module under rtl/core, depends on nothing

package hmcs_pkg;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_DRIVE   = 3'd1,
      OP_TIMED   = 3'd2,
      OP_BRAKE   = 3'd3,
      OP_COAST   = 3'd4,
      OP_REVERSE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      MODE_COAST       = 3'd0,
      MODE_RUN         = 3'd1,
      MODE_TIMED_RUN   = 3'd2,
      MODE_TIMED_BRAKE = 3'd3,
      MODE_HELD_BRAKE  = 3'd4
   } mode_type;

   typedef enum logic {
      CSR_DUTY_FLOOR   = 1'b0,
      CSR_DUTY_CEILING = 1'b1
   } csr_index_type;

   localparam logic [7:0]  DUTY_FLOOR_RESET   = 8'd0;
   localparam logic [7:0]  DUTY_CEILING_RESET = 8'd255;
   localparam logic [7:0]  FULL_DUTY          = 8'd255;
   localparam logic [16:0] SAT_MAGNITUDE      = 17'd1000;
   localparam logic [15:0] BRAKE_TICKS        = 16'd100;
   localparam logic [15:0] REVERSE_TICKS      = 16'd500;
   localparam logic [16:0] ELAPSED_MAX        = 17'h1FFFF;

   // division by 998 as multiply by ceil(2^28/998), exact for numerators below 2^18
   localparam int          MAP_SHIFT = 28;
   localparam logic [26:0] MAP_RECIP = 27'd268974;
   // 997 * recip turns the floor into a ceiling for a descending span
   localparam logic [36:0] MAP_ROUND = 37'd268167078;
   // span 255 times recip
   localparam logic [26:0] SPAN_RECIP_RESET = 27'd68588370;

   typedef struct packed {
      logic [7:0]  floor;
      logic [26:0] span_recip;
      logic        descend;
   } map_cfg_type;

   typedef struct packed {
      logic              signed [8:0] applied_speed;
      mode_type          mode;
      logic [7:0]        duty;
      logic              dir_b;
      logic              dir_a;
   } result_type;

endpackage

[rtl/core/hmcs_csr.sv]
// hmcs_csr: duty floor and ceiling registers plus the precomputed span reciprocal
// depends on hmcs_pkg

module hmcs_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [7:0]           csr_data,
   output hmcs_pkg::map_cfg_type cfg
);

   logic [7:0]  floor_ff, floor_in;
   logic [7:0]  ceiling_ff, ceiling_in;
   logic [26:0] span_recip_ff, span_recip_in;
   logic        descend_ff, descend_in;
   logic [7:0]  span;

   always_comb begin
      floor_in   = floor_ff;
      ceiling_in = ceiling_ff;
      if (csr_valid) begin
         unique case (hmcs_pkg::csr_index_type'(csr_index))
            hmcs_pkg::CSR_DUTY_FLOOR:   floor_in   = csr_data;
            hmcs_pkg::CSR_DUTY_CEILING: ceiling_in = csr_data;
            default: ;
         endcase
      end
      descend_in    = (ceiling_in < floor_in);
      span          = descend_in ? (floor_in - ceiling_in) : (ceiling_in - floor_in);
      span_recip_in = 27'(span) * hmcs_pkg::MAP_RECIP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff      <= hmcs_pkg::DUTY_FLOOR_RESET;
         ceiling_ff    <= hmcs_pkg::DUTY_CEILING_RESET;
         span_recip_ff <= hmcs_pkg::SPAN_RECIP_RESET;
         descend_ff    <= 1'b0;
      end else begin
         floor_ff      <= floor_in;
         ceiling_ff    <= ceiling_in;
         span_recip_ff <= span_recip_in;
         descend_ff    <= descend_in;
      end
   end

   assign cfg.floor      = floor_ff;
   assign cfg.span_recip = span_recip_ff;
   assign cfg.descend    = descend_ff;

endmodule

[rtl/core/hmcs_duty_map.sv]
// hmcs_duty_map: maps a signed speed onto an enable duty
// depends on hmcs_pkg, configuration from hmcs_csr

module hmcs_duty_map (
   input  logic signed [16:0]    speed,
   input  hmcs_pkg::map_cfg_type cfg,
   output logic [7:0]            duty
);

   logic [16:0] mag;
   logic [9:0]  step;
   logic [36:0] prod;
   logic [36:0] scaled;
   logic [7:0]  quot;

   always_comb begin
      mag    = speed[16] ? 17'(-speed) : 17'(speed);
      step   = mag[9:0] - 10'd1;
      prod   = 37'(step) * 37'(cfg.span_recip);
      scaled = prod + (cfg.descend ? hmcs_pkg::MAP_ROUND : 37'd0);
      quot   = scaled[hmcs_pkg::MAP_SHIFT +: 8];
      priority if (mag == 17'd0) begin
         duty = 8'd0;
      end else if (mag >= hmcs_pkg::SAT_MAGNITUDE) begin
         duty = hmcs_pkg::FULL_DUTY;
      end else if (cfg.descend) begin
         duty = cfg.floor - quot;
      end else begin
         duty = cfg.floor + quot;
      end
   end

endmodule

[rtl/core/hmcs_seq.sv]
// hmcs_seq: input register, bridge state and result register of the sequencer
// depends on hmcs_pkg, gets mapped duty from hmcs_duty_map

module hmcs_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_operation,
   input  logic signed [15:0]       req_speed_cmd,
   input  logic [15:0]              req_duration_ms,
   output logic signed [16:0]       map_speed,
   input  logic [7:0]               map_duty,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hmcs_pkg::result_type     rsp_result
);

   logic                  in_valid_ff;
   hmcs_pkg::op_type      op_ff;
   logic signed [15:0]    speed_ff;
   logic [15:0]           duration_ff;

   hmcs_pkg::mode_type    mode_ff, mode_in;
   logic signed [8:0]     stored_ff, stored_in;
   logic [16:0]           elapsed_ff, elapsed_in;
   logic [15:0]           hold_ff, hold_in;
   logic                  line_a_ff, line_a_in;
   logic                  line_b_ff, line_b_in;
   logic [7:0]            duty_ff, duty_in;

   logic                  rsp_valid_ff;
   hmcs_pkg::result_type  rsp_result_ff;

   logic                  advance;
   logic [16:0]           elapsed_inc;
   logic signed [8:0]     drive_speed;
   logic                  drive_neg;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // reverse re-maps the negated stored duty
   assign map_speed = (op_ff == hmcs_pkg::OP_REVERSE) ? -17'(stored_ff) : 17'(speed_ff);

   always_comb begin
      drive_neg   = map_speed[16] && (map_duty != 8'd0);
      drive_speed = drive_neg ? -$signed({1'b0, map_duty}) : $signed({1'b0, map_duty});
      elapsed_inc = (elapsed_ff < hmcs_pkg::ELAPSED_MAX) ? elapsed_ff + 17'd1 : elapsed_ff;

      mode_in    = mode_ff;
      stored_in  = stored_ff;
      elapsed_in = elapsed_ff;
      hold_in    = hold_ff;
      line_a_in  = line_a_ff;
      line_b_in  = line_b_ff;
      duty_in    = duty_ff;

      unique case (op_ff)
         hmcs_pkg::OP_TICK: begin
            elapsed_in = elapsed_inc;
            if (mode_ff == hmcs_pkg::MODE_TIMED_RUN && elapsed_inc > {1'b0, hold_ff}) begin
               mode_in    = hmcs_pkg::MODE_TIMED_BRAKE;
               line_a_in  = 1'b0;
               line_b_in  = 1'b0;
               duty_in    = hmcs_pkg::FULL_DUTY;
               hold_in    = hmcs_pkg::BRAKE_TICKS;
               elapsed_in = 17'd0;
            end else if (mode_ff == hmcs_pkg::MODE_TIMED_BRAKE &&
                         elapsed_inc > {1'b0, hold_ff}) begin
               mode_in   = hmcs_pkg::MODE_COAST;
               line_a_in = 1'b0;
               line_b_in = 1'b0;
               duty_in   = 8'd0;
            end
         end
         hmcs_pkg::OP_DRIVE, hmcs_pkg::OP_TIMED, hmcs_pkg::OP_REVERSE: begin
            stored_in = drive_speed;
            line_a_in = !drive_neg;
            line_b_in = drive_neg;
            duty_in   = map_duty;
            if (op_ff == hmcs_pkg::OP_DRIVE) begin
               mode_in = hmcs_pkg::MODE_RUN;
            end else begin
               mode_in    = hmcs_pkg::MODE_TIMED_RUN;
               elapsed_in = 17'd0;
               hold_in    = (op_ff == hmcs_pkg::OP_TIMED) ? duration_ff
                                                          : hmcs_pkg::REVERSE_TICKS;
            end
         end
         hmcs_pkg::OP_BRAKE: begin
            mode_in   = hmcs_pkg::MODE_HELD_BRAKE;
            line_a_in = 1'b0;
            line_b_in = 1'b0;
            duty_in   = hmcs_pkg::FULL_DUTY;
         end
         hmcs_pkg::OP_COAST: begin
            mode_in   = hmcs_pkg::MODE_COAST;
            line_a_in = 1'b0;
            line_b_in = 1'b0;
            duty_in   = 8'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= hmcs_pkg::MODE_COAST;
         stored_ff    <= 9'sd0;
         elapsed_ff   <= 17'd0;
         hold_ff      <= 16'd0;
         line_a_ff    <= 1'b0;
         line_b_ff    <= 1'b0;
         duty_ff      <= 8'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            stored_ff    <= stored_in;
            elapsed_ff   <= elapsed_in;
            hold_ff      <= hold_in;
            line_a_ff    <= line_a_in;
            line_b_ff    <= line_b_in;
            duty_ff      <= duty_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff       <= hmcs_pkg::op_type'(req_operation);
         speed_ff    <= req_speed_cmd;
         duration_ff <= req_duration_ms;
      end
      if (advance) begin
         rsp_result_ff.dir_a         <= line_a_in;
         rsp_result_ff.dir_b         <= line_b_in;
         rsp_result_ff.duty          <= duty_in;
         rsp_result_ff.mode          <= mode_in;
         rsp_result_ff.applied_speed <= stored_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

[rtl/core/hbridge_motor_command_sequencer_top.sv]
// Top level of the h-bridge motor command sequencer: one item per clock unless rsp
// back-pressure stalls it. An accepted req goes into the input register, then through
// the mapping multiply and state update into the result register, then out as rsp. A
// full result register still takes an item into an empty input register. Csr writes
// are registered. Depends on hmcs_pkg, hmcs_csr, hmcs_duty_map and hmcs_seq.

module hbridge_motor_command_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // speed_cmd[15:0], duration_ms[31:16]
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // dir_a[0], dir_b[1], duty[9:2], mode[12:10],
                                    // applied_speed[21:13], zero[23:22]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   hmcs_pkg::map_cfg_type cfg;
   hmcs_pkg::result_type  result;
   logic signed [16:0]    map_speed;
   logic [7:0]            map_duty;

   assign csr_ready = 1'b1;

   hmcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hmcs_duty_map u_duty_map (
      .speed (map_speed),
      .cfg   (cfg),
      .duty  (map_duty)
   );

   hmcs_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_operation   (req_tuser),
      .req_speed_cmd   ($signed(req_tdata[15:0])),
      .req_duration_ms (req_tdata[31:16]),
      .map_speed       (map_speed),
      .map_duty        (map_duty),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_result      (result)
   );

   assign rsp_tdata = {2'b00, result.applied_speed, result.mode, result.duty,
                       result.dir_b, result.dir_a};

endmodule
